[rtl/stream_find_replace_top_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the stream find-and-replace block
// Shared assertion forms, clocked on clk_i; SFR_ASSERT is disabled by the active-low reset rst_ni.
// ---------------------------------------------------------------------------
`ifndef STREAM_FIND_REPLACE_TOP_DEFINES_SVH
`define STREAM_FIND_REPLACE_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/sfr_pkg.sv]
// ---------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the stream find-and-replace modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;

  // One job holds every byte that a single request emits: an evicted byte
  // followed by either the replacement or the flushed window.
  localparam int JOB_BYTES = 1 + ((MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
                                                                  : MAX_REPLACEMENT);
  localparam int JOB_W     = JOB_BYTES * 8;
  localparam int CNT_W     = $clog2(JOB_BYTES + 1);
  localparam int IDX_W     = (JOB_BYTES > 1) ? $clog2(JOB_BYTES) : 1;
  localparam int FILL_W    = $clog2(MAX_PATTERN + 1);

  localparam int QDEPTH    = 2;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 8'd3;

  typedef struct packed {
    logic [JOB_W-1:0] data;   // byte k in bits 8k+7:8k
    logic [CNT_W-1:0] cnt;    // number of data bytes, 0 for an end marker only
    logic             last;   // job closes the text
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/sfr_front.sv]
// ---------------------------------------------------------------------------
// sfr_front
// Holds configuration and the match window; turns each byte into a job.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfr_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       in_byte_i,
  input  logic                             in_last_i,
  input  sfr_pkg::q_status_t               q_stat_i,
  output logic                             push_o,
  output sfr_pkg::job_t                    job_o
);

  localparam int MP     = sfr_pkg::MAX_PATTERN;
  localparam int MR     = sfr_pkg::MAX_REPLACEMENT;
  localparam int FILL_W = sfr_pkg::FILL_W;
  localparam int CNT_W  = sfr_pkg::CNT_W;
  localparam int JOB_W  = sfr_pkg::JOB_W;

  logic [63:0]           pat_q, rep_q;
  logic [3:0]            plen_q, rlen_q;
  logic [MP-1:0][7:0]    win_q;
  logic [FILL_W-1:0]     fill_q, fill_d;

  logic [FILL_W-1:0]     plen_eff, fill_mid, fill_new;
  logic [CNT_W-1:0]      rlen_eff, cnt;
  logic                  pass, evict, hit, accept, plen_wr;
  logic [MP-1:0][7:0]    win_shift, win_new;
  logic [JOB_W-1:0]      src, seq;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign plen_wr    = cfg_valid_i && (cfg_index_i == sfr_pkg::CFG_PATTERN_LENGTH);

  always_comb begin
    plen_eff = (plen_q > 4'(MP)) ? FILL_W'(MP) : FILL_W'(plen_q);
    rlen_eff = (rlen_q > 4'(MR)) ? CNT_W'(MR) : CNT_W'(rlen_q);
    pass     = (plen_eff == '0);
    evict    = !pass && (fill_q >= plen_eff);
    fill_mid = evict ? (plen_eff - FILL_W'(1)) : fill_q;

    // Drop the oldest byte when the window is full, then place the new one.
    win_shift = evict ? (win_q >> 8) : win_q;
    for (int i = 0; i < MP; i++) begin
      win_new[i] = (FILL_W'(i) == fill_mid) ? in_byte_i : win_shift[i];
    end
    fill_new = fill_mid + FILL_W'(1);

    hit = !pass && (fill_new == plen_eff);
    for (int i = 0; i < MP; i++) begin
      if ((FILL_W'(i) < plen_eff) && (win_new[i] != pat_q[8*i +: 8])) begin
        hit = 1'b0;
      end
    end

    // Bytes after the evicted one: replacement on a hit, else the window.
    src = '0;
    for (int k = 0; k < MR; k++) begin
      if (hit) begin
        src[8*k +: 8] = rep_q[8*k +: 8];
      end
    end
    for (int k = 0; k < MP; k++) begin
      if (!hit) begin
        src[8*k +: 8] = win_new[k];
      end
    end

    if (pass) begin
      seq    = JOB_W'(in_byte_i);
      cnt    = CNT_W'(1);
      fill_d = fill_q;
    end else begin
      seq    = evict ? ((src << 8) | JOB_W'(win_q[0])) : src;
      cnt    = CNT_W'(evict) + (hit ? rlen_eff : (in_last_i ? CNT_W'(fill_new) : '0));
      fill_d = (hit || in_last_i) ? '0 : fill_new;
    end
  end

  assign push_o    = accept && ((cnt != '0) || in_last_i);
  assign job_o.data = seq;
  assign job_o.cnt  = cnt;
  assign job_o.last = in_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      rep_q  <= '0;
      plen_q <= '0;
      rlen_q <= '0;
      fill_q <= '0;
    end else begin
      if (plen_wr) begin
        fill_q <= '0;
      end else if (accept) begin
        fill_q <= fill_d;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          sfr_pkg::CFG_PATTERN_BYTES: begin
            pat_q <= cfg_data_i;
          end
          sfr_pkg::CFG_PATTERN_LENGTH: begin
            plen_q <= cfg_data_i[3:0];
          end
          sfr_pkg::CFG_REPLACEMENT_BYTES: begin
            rep_q <= cfg_data_i;
          end
          sfr_pkg::CFG_REPLACEMENT_LENGTH: begin
            rlen_q <= cfg_data_i[3:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Window bytes are only read below the fill level, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (accept && !pass) begin
      win_q <= win_new;
    end
  end

endmodule

[rtl/sfr_queue.sv]
// ---------------------------------------------------------------------------
// sfr_queue
// Short job queue between the front and back parts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sfr_pkg::job_t      job_i,
  input  logic               pop_i,
  output sfr_pkg::job_t      head_o,
  output sfr_pkg::q_status_t stat_o
);

  localparam int QD    = sfr_pkg::QDEPTH;
  localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int CNT_W = $clog2(QD + 1);

  sfr_pkg::job_t      mem_q [QD];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;

  assign stat_o.full  = (cnt_q == CNT_W'(QD));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(QD - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(QD - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/sfr_back.sv]
// ---------------------------------------------------------------------------
// sfr_back
// Walks the head job byte by byte into the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfr_pkg::job_t      head_i,
  input  sfr_pkg::q_status_t q_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               byte_valid_o,
  output logic               out_last_o
);

  localparam int IDX_W = sfr_pkg::IDX_W;
  localparam int CNT_W = sfr_pkg::CNT_W;

  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] last_idx;
  logic             advance, take, at_end;
  logic             valid_q, bv_q, last_q;
  logic [7:0]       byte_q;

  assign advance  = !valid_q || out_ready_i;
  assign take     = advance && !q_stat_i.empty;
  assign last_idx = (head_i.cnt == '0) ? '0 : IDX_W'(head_i.cnt - CNT_W'(1));
  assign at_end   = (idx_q == last_idx);
  assign pop_o    = take && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (advance) begin
      valid_q <= !q_stat_i.empty;
      if (take) begin
        idx_q <= at_end ? '0 : idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= (head_i.cnt == '0) ? 8'h00 : head_i.data[8*idx_q +: 8];
      bv_q   <= (head_i.cnt != '0);
      last_q <= head_i.last && at_end;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign byte_valid_o = bv_q;
  assign out_last_o   = last_q;

endmodule

[rtl/stream_find_replace_top.sv]
// ---------------------------------------------------------------------------
// stream_find_replace_top
// Streaming find-and-replace over a byte stream.
// ---------------------------------------------------------------------------
// The block takes one text byte per request and rewrites every leftmost,
// non-overlapping occurrence of the pattern (1 to 8 bytes) with the
// replacement (0 to 8 bytes); a pattern length of 0 passes bytes unchanged.
// A byte marked last flushes the held window and its final result carries
// out_last; if that byte yields no data, a single result with byte_valid 0
// carries the end marker. Throughput is one input byte per cycle while each
// byte yields at most one result and out_ready is high. The back end emits
// one result per cycle from the head job of a two-entry queue, stalled while
// out_ready is low; input ready drops while that queue is full. An accepted
// byte's job is written to the queue, then to the output register. Write
// configuration only while the block is idle; a write to the pattern length
// drops the bytes held in the window.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stream_find_replace_top_defines.svh"

module stream_find_replace_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // text input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     in_byte_i,
  input  logic                           in_last_i,
  // rewritten text output
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     out_byte_o,
  output logic                           byte_valid_o,
  output logic                           out_last_o
);

  sfr_pkg::job_t      push_job;
  sfr_pkg::job_t      head_job;
  sfr_pkg::q_status_t q_stat;
  logic               push;
  logic               pop;

  // Registers take a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // Front: hold the window, compare against the pattern, build one job per
  // request that has anything to emit.
  sfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .job_o       (push_job)
  );

  // Queue: decouple the front from output backpressure.
  sfr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .head_o (head_job),
    .stat_o (q_stat)
  );

  // Back: advance through the head job one result per cycle while out_ready is high.
  sfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_job),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .out_last_o   (out_last_o)
  );

  // An end-marker-only result must close the text.
  `SFR_ASSERT(a_marker_is_last, (out_valid_o && !byte_valid_o) |-> out_last_o, "marker without last")
  // Never push a job into a full queue.
  `SFR_ASSERT_ALWAYS(a_no_overflow, !(push && q_stat.full), "job queue overflow")
  // Never pop an empty queue.
  `SFR_ASSERT(a_no_underflow, pop |-> !q_stat.empty, "job queue underflow")

endmodule
